FILE: hw/rtl/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

	typedef logic [30:0] word_t;
	typedef logic [5:0]  ptr_t;
	typedef logic [5:0]  slot_t;
	typedef logic [1:0]  pass_t;

	localparam int    TABLE_WORDS = 55;
	localparam int    MIX_PASSES  = 4;
	localparam word_t MODULUS     = 31'h7FFF_FFFF;
	localparam word_t RESET_SEED  = 31'd161803398;
	localparam slot_t LAST_SLOT   = 6'(TABLE_WORDS - 1);
	localparam slot_t FILL_STRIDE = 6'd21;
	localparam slot_t MIX_OFFSET  = 6'd30;
	localparam ptr_t  TRAIL_START = 6'd31;
	localparam ptr_t  WRAP_AT     = 6'd56;
	localparam pass_t LAST_PASS   = 2'(MIX_PASSES - 1);

	typedef enum logic [1:0] {
		OP_DRAW    = 2'd0,
		OP_SAVE    = 2'd1,
		OP_RESTORE = 2'd2,
		OP_RESEED  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_SAVE,
		ST_RESTORE,
		ST_FILL,
		ST_MIX,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic  valid;
		word_t raw;
		word_t limit;
	} scale_req_t;

	function automatic word_t sub_mod(word_t a, word_t b);
		logic [31:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[31]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[30:0];
	endfunction

	function automatic ptr_t advance(ptr_t p);
		ptr_t r;
		if (p >= WRAP_AT - 6'd1) begin
			r = 6'd1;
		end else begin
			r = p + 6'd1;
		end
		return r;
	endfunction

	// Adds a stride below the table size and folds the sum back into 0..54.
	function automatic slot_t wrap_add(slot_t a, slot_t b);
		logic [6:0] s;
		slot_t      r;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 7'(TABLE_WORDS)) begin
			r = 6'(s - 7'(TABLE_WORDS));
		end else begin
			r = s[5:0];
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/slr_scale.sv
`timescale 1ns / 1ps

module slr_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  slr_pkg::scale_req_t req,
	output logic                ready,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [63:0]         m_axis_tdata   // raw_value, scaled_value, zero pad
);

	logic           v_s1;
	slr_pkg::word_t raw_s1;
	slr_pkg::word_t lim_s1;
	logic           v_s2;
	slr_pkg::word_t raw_s2;
	logic [61:0]    prod_s2;
	logic           out_v_q;
	logic [63:0]    tdata_q;

	logic           out_load;
	logic           st2_load;
	slr_pkg::word_t hi;
	slr_pkg::word_t lo;
	logic [31:0]    fold;
	slr_pkg::word_t quot;

	assign out_load = v_s2 && (!out_v_q || m_axis_tready);
	assign st2_load = v_s1 && (!v_s2 || out_load);
	assign ready    = !v_s1 || st2_load;

	// Since 2^31 = M + 1, P = hi*M + (hi + lo) and hi + lo stays at or below 2M.
	always_comb begin
		hi   = prod_s2[61:31];
		lo   = prod_s2[30:0];
		fold = {1'b0, hi} + {1'b0, lo};
		if (fold >= {slr_pkg::MODULUS, 1'b0}) begin
			quot = hi + 31'd2;
		end else if (fold >= {1'b0, slr_pkg::MODULUS}) begin
			quot = hi + 31'd1;
		end else begin
			quot = hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.valid) begin
				v_s1 <= 1'b1;
			end else if (st2_load) begin
				v_s1 <= 1'b0;
			end
			if (st2_load) begin
				v_s2 <= 1'b1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			raw_s1 <= req.raw;
			lim_s1 <= req.limit;
		end
		if (st2_load) begin
			raw_s2  <= raw_s1;
			prod_s2 <= 62'(raw_s1) * 62'(lim_s1);
		end
		if (out_load) begin
			tdata_q <= {2'b00, quot, raw_s2};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = tdata_q;

endmodule

FILE: hw/rtl/subtractive_lagged_rng.sv
// Channel   Direction  Payload
// s_axis    in         tdata: range_limit; tuser: op
// m_axis    out        tdata: raw_value, scaled_value
// cfg       in         data: seed_value
//
// A draw reads the table memory in the accept cycle and writes it back in the
// next. The result then passes the scaler's input, product and output registers.
// Save and restore copy one table word per cycle.
// A reseed makes 55 fill writes and 220 mixing steps, one per cycle.
// After reset the block reseeds itself from the reset seed.
// A stalled output holds its word; the block then keeps two more results inside.
`timescale 1ns / 1ps

module subtractive_lagged_rng (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // range_limit, zero pad
	input  logic [1:0]  s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // raw_value, scaled_value, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data        // seed_value
);

	slr_pkg::state_t state_q;
	slr_pkg::state_t state_d;

	slr_pkg::word_t seed_q;
	slr_pkg::ptr_t  lead_q;
	slr_pkg::ptr_t  trail_q;
	slr_pkg::ptr_t  sv_lead_q;
	slr_pkg::ptr_t  sv_trail_q;
	slr_pkg::slot_t cnt_q;
	slr_pkg::pass_t pass_q;
	slr_pkg::slot_t pos_q;
	slr_pkg::word_t prev_q;
	slr_pkg::word_t cur_q;
	slr_pkg::word_t limit_q;
	logic           report_q;

	logic           rmw_v_s1;
	slr_pkg::slot_t rmw_addr_s1;
	logic           svc_v_s1;
	logic           rsc_v_s1;
	slr_pkg::slot_t cp_addr_s1;

	slr_pkg::word_t lag_mem [slr_pkg::TABLE_WORDS];
	slr_pkg::word_t sv_mem  [slr_pkg::TABLE_WORDS];
	slr_pkg::word_t rd_a_q;
	slr_pkg::word_t rd_b_q;
	slr_pkg::word_t sv_rd_q;

	logic                in_acc;
	slr_pkg::op_t        op_in;
	slr_pkg::ptr_t       lead_nx;
	slr_pkg::ptr_t       trail_nx;
	slr_pkg::word_t      diff;
	slr_pkg::slot_t      rd_addr_a;
	slr_pkg::slot_t      rd_addr_b;
	logic                lag_we;
	slr_pkg::slot_t      lag_waddr;
	slr_pkg::word_t      lag_wdata;
	logic                counting;
	slr_pkg::scale_req_t req;
	logic                scale_ready;

	assign op_in     = slr_pkg::op_t'(s_axis_tuser);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign lead_nx   = slr_pkg::advance(lead_q);
	assign trail_nx  = slr_pkg::advance(trail_q);
	assign diff      = slr_pkg::sub_mod(rd_a_q, rd_b_q);
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == slr_pkg::ST_IDLE) && scale_ready;
	assign counting  = (state_q == slr_pkg::ST_SAVE) || (state_q == slr_pkg::ST_RESTORE) ||
	                   (state_q == slr_pkg::ST_FILL) || (state_q == slr_pkg::ST_MIX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			slr_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (op_in)
						slr_pkg::OP_DRAW:    state_d = slr_pkg::ST_DRAW;
						slr_pkg::OP_SAVE:    state_d = slr_pkg::ST_SAVE;
						slr_pkg::OP_RESTORE: state_d = slr_pkg::ST_RESTORE;
						slr_pkg::OP_RESEED:  state_d = slr_pkg::ST_FILL;
						default:             state_d = slr_pkg::ST_IDLE;
					endcase
				end
			end
			slr_pkg::ST_DRAW: state_d = slr_pkg::ST_IDLE;
			slr_pkg::ST_SAVE, slr_pkg::ST_RESTORE: begin
				if (cnt_q == slr_pkg::LAST_SLOT) begin
					state_d = slr_pkg::ST_FIN;
				end
			end
			slr_pkg::ST_FILL: begin
				if (cnt_q == slr_pkg::LAST_SLOT) begin
					state_d = slr_pkg::ST_MIX;
				end
			end
			slr_pkg::ST_MIX: begin
				if (cnt_q == slr_pkg::LAST_SLOT && pass_q == slr_pkg::LAST_PASS) begin
					state_d = slr_pkg::ST_FIN;
				end
			end
			slr_pkg::ST_FIN: state_d = slr_pkg::ST_IDLE;
			default: state_d = slr_pkg::ST_IDLE;
		endcase
	end

	// Word n of the table sits in slot n-1; the mixing partner of slot j is j+31 mod 55.
	always_comb begin
		rd_addr_a = cnt_q;
		rd_addr_b = slr_pkg::wrap_add(cnt_q, slr_pkg::MIX_OFFSET + 6'd1);
		req       = '0;
		lag_we    = 1'b0;
		lag_waddr = rmw_addr_s1;
		lag_wdata = diff;
		case (state_q)
			slr_pkg::ST_IDLE: begin
				rd_addr_a = lead_nx - 6'd1;
				rd_addr_b = trail_nx - 6'd1;
			end
			slr_pkg::ST_DRAW: begin
				req.valid = 1'b1;
				req.raw   = diff;
				req.limit = limit_q;
			end
			slr_pkg::ST_FIN: begin
				req.valid = report_q;
			end
			default: begin
			end
		endcase
		if (state_q == slr_pkg::ST_FILL) begin
			lag_we = 1'b1;
			if (cnt_q == '0) begin
				lag_waddr = slr_pkg::LAST_SLOT;
				lag_wdata = seed_q;
			end else begin
				lag_waddr = pos_q - 6'd1;
				lag_wdata = cur_q;
			end
		end else if (rmw_v_s1) begin
			lag_we = 1'b1;
		end else if (rsc_v_s1) begin
			lag_we    = 1'b1;
			lag_waddr = cp_addr_s1;
			lag_wdata = sv_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= slr_pkg::ST_FILL;
			seed_q   <= slr_pkg::RESET_SEED;
			lead_q   <= '0;
			trail_q  <= slr_pkg::TRAIL_START;
			cnt_q    <= '0;
			pass_q   <= '0;
			report_q <= 1'b0;
			rmw_v_s1 <= 1'b0;
			svc_v_s1 <= 1'b0;
			rsc_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			rmw_v_s1 <= (in_acc && op_in == slr_pkg::OP_DRAW) || (state_q == slr_pkg::ST_MIX);
			svc_v_s1 <= state_q == slr_pkg::ST_SAVE;
			rsc_v_s1 <= state_q == slr_pkg::ST_RESTORE;
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (counting) begin
				cnt_q <= (cnt_q == slr_pkg::LAST_SLOT) ? '0 : cnt_q + 6'd1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q != slr_pkg::ST_MIX) begin
				pass_q <= '0;
			end else if (cnt_q == slr_pkg::LAST_SLOT) begin
				pass_q <= pass_q + 2'd1;
			end
			if (in_acc) begin
				report_q <= 1'b1;
				case (op_in)
					slr_pkg::OP_DRAW: begin
						lead_q  <= lead_nx;
						trail_q <= trail_nx;
					end
					slr_pkg::OP_RESTORE: begin
						lead_q  <= sv_lead_q;
						trail_q <= sv_trail_q;
					end
					slr_pkg::OP_RESEED: begin
						lead_q  <= '0;
						trail_q <= slr_pkg::TRAIL_START;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rmw_addr_s1 <= rd_addr_a;
		cp_addr_s1  <= cnt_q;
		if (in_acc) begin
			limit_q <= s_axis_tdata[30:0];
			if (op_in == slr_pkg::OP_SAVE) begin
				sv_lead_q  <= lead_q;
				sv_trail_q <= trail_q;
			end
		end
		if (state_q == slr_pkg::ST_FILL) begin
			if (cnt_q == '0) begin
				prev_q <= seed_q;
				cur_q  <= 31'd1;
				pos_q  <= slr_pkg::FILL_STRIDE;
			end else begin
				cur_q  <= slr_pkg::sub_mod(prev_q, cur_q);
				prev_q <= cur_q;
				pos_q  <= slr_pkg::wrap_add(pos_q, slr_pkg::FILL_STRIDE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lag_we) begin
			lag_mem[lag_waddr] <= lag_wdata;
		end
		rd_a_q <= lag_mem[rd_addr_a];
		rd_b_q <= lag_mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (svc_v_s1) begin
			sv_mem[cp_addr_s1] <= rd_a_q;
		end
		sv_rd_q <= sv_mem[cnt_q];
	end

	slr_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.ready         (scale_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef ASSERT_OFF
	a_draw_writes_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op_in == slr_pkg::OP_DRAW) |=> (state_q == slr_pkg::ST_DRAW && rmw_v_s1))
		else $error("draw did not schedule its write back");

	a_fill_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slr_pkg::ST_FILL) |-> (!rmw_v_s1 && !rsc_v_s1))
		else $error("table write port contended during fill");

	a_mix_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slr_pkg::ST_MIX && rmw_v_s1) |->
		(rd_addr_a != rmw_addr_s1 && rd_addr_b != rmw_addr_s1))
		else $error("mixing read hits the word being written");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> scale_ready)
		else $error("result issued while the scaler is full");
`endif

endmodule

FILE: bench/subtractive_lagged_rng_tb.sv
`timescale 1ns / 1ps

module subtractive_lagged_rng_tb;

	localparam longint MOD_P       = 64'd2147483647;
	localparam int     WORD_TARGET = 1800;
	localparam int     SETTLE_WAIT = 300;
	localparam int     STALL_LIMIT = 20000;
	localparam int     LONG_HOLD   = 600;

	typedef enum logic [1:0] {
		K_WORD,
		K_SEED,
		K_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t     kind;
		slr_pkg::op_t   op;
		slr_pkg::word_t limit;
		slr_pkg::word_t seed;
	} stim_step_t;

	typedef struct {
		slr_pkg::word_t raw;
		slr_pkg::word_t scaled;
	} draw_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [30:0] cfg_data = '0;

	subtractive_lagged_rng dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Generator state as the testbench expects it to be.
	slr_pkg::word_t lag_words[1:55];
	slr_pkg::word_t snap_words[1:55];
	slr_pkg::ptr_t  lead_idx;
	slr_pkg::ptr_t  trail_idx;
	slr_pkg::ptr_t  snap_lead_idx;
	slr_pkg::ptr_t  snap_trail_idx;
	slr_pkg::word_t seed_reg;

	stim_step_t   stim_q[$];
	draw_result_t expected_words[$];
	bit           snapshot_planned;
	int           words_planned;

	int sent_cnt;
	int result_cnt;
	int fail_cnt;
	int seed_writes;
	int op_cnt[4];

	function automatic slr_pkg::word_t mod_diff(longint a, longint b);
		longint d;
		d = a - b;
		if (d < 0) begin
			d = d + MOD_P;
		end
		return slr_pkg::word_t'(d);
	endfunction

	function automatic slr_pkg::ptr_t next_idx(slr_pkg::ptr_t p);
		slr_pkg::ptr_t r;
		r = p + 6'd1;
		if (r > 6'd55) begin
			r = 6'd1;
		end
		return r;
	endfunction

	function automatic void refill_from_seed();
		longint prev;
		longint cur;
		int     pos;
		int     other;
		prev = longint'(seed_reg);
		cur = 1;
		lag_words[55] = seed_reg;
		for (int i = 1; i <= 54; i++) begin
			pos = (21 * i) % 55;
			lag_words[pos] = slr_pkg::word_t'(cur);
			cur = prev - cur;
			if (cur < 0) begin
				cur = cur + MOD_P;
			end
			prev = longint'(lag_words[pos]);
		end
		for (int pass = 0; pass < 4; pass++) begin
			for (int i = 1; i <= 55; i++) begin
				other = 1 + (i + 30) % 55;
				lag_words[i] = mod_diff(longint'(lag_words[i]), longint'(lag_words[other]));
			end
		end
		lead_idx = 6'd0;
		trail_idx = 6'd31;
	endfunction

	function automatic draw_result_t predict_word(slr_pkg::op_t op, slr_pkg::word_t limit);
		draw_result_t res;
		longint unsigned prod;
		res.raw = '0;
		res.scaled = '0;
		case (op)
			slr_pkg::OP_DRAW: begin
				lead_idx = next_idx(lead_idx);
				trail_idx = next_idx(trail_idx);
				lag_words[lead_idx] = mod_diff(longint'(lag_words[lead_idx]),
					longint'(lag_words[trail_idx]));
				res.raw = lag_words[lead_idx];
				prod = 64'(res.raw) * 64'(limit);
				res.scaled = slr_pkg::word_t'(prod / 64'(MOD_P));
			end
			slr_pkg::OP_SAVE: begin
				snap_words = lag_words;
				snap_lead_idx = lead_idx;
				snap_trail_idx = trail_idx;
			end
			slr_pkg::OP_RESTORE: begin
				lag_words = snap_words;
				lead_idx = snap_lead_idx;
				trail_idx = snap_trail_idx;
			end
			default: begin
				refill_from_seed();
			end
		endcase
		return res;
	endfunction

	function automatic void push_word(slr_pkg::op_t op, slr_pkg::word_t limit);
		stim_step_t s;
		s.kind = K_WORD;
		s.op = op;
		s.limit = limit;
		s.seed = '0;
		stim_q.push_back(s);
		words_planned++;
	endfunction

	function automatic void push_seed(slr_pkg::word_t seed);
		stim_step_t s;
		s.kind = K_SEED;
		s.op = slr_pkg::OP_DRAW;
		s.limit = '0;
		s.seed = seed;
		stim_q.push_back(s);
	endfunction

	function automatic void push_drain();
		stim_step_t s;
		s.kind = K_DRAIN;
		s.op = slr_pkg::OP_DRAW;
		s.limit = '0;
		s.seed = '0;
		stim_q.push_back(s);
	endfunction

	function automatic slr_pkg::word_t pick_limit();
		int r;
		slr_pkg::word_t v;
		r = $urandom_range(0, 99);
		v = slr_pkg::word_t'($urandom());
		if (r < 10) begin
			v = '0;
		end else if (r < 20) begin
			v = '1;
		end else if (r < 30) begin
			v = slr_pkg::word_t'($urandom_range(1, 16));
		end else if (r < 40) begin
			v = slr_pkg::word_t'(1) << $urandom_range(0, 30);
		end
		return v;
	endfunction

	function automatic slr_pkg::word_t pick_seed();
		int r;
		slr_pkg::word_t v;
		r = $urandom_range(0, 9);
		v = slr_pkg::word_t'($urandom());
		case (r)
			0: v = '0;
			1: v = '1;
			2: v = 31'h7FFF_FFFE;
			3: v = 31'd1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic slr_pkg::op_t pick_op();
		int r;
		slr_pkg::op_t op;
		r = $urandom_range(0, 99);
		op = slr_pkg::OP_DRAW;
		if (r >= 84 && r < 91) begin
			op = slr_pkg::OP_SAVE;
			snapshot_planned = 1'b1;
		end else if (r >= 91 && r < 96) begin
			op = snapshot_planned ? slr_pkg::OP_RESTORE : slr_pkg::OP_DRAW;
		end else if (r >= 96) begin
			op = slr_pkg::OP_RESEED;
		end
		return op;
	endfunction

	function automatic int pick_gap(bit bursty);
		int r;
		int g;
		r = $urandom_range(0, 99);
		g = 0;
		if (!bursty) begin
			if (r >= 60 && r < 92) begin
				g = $urandom_range(1, 3);
			end else if (r >= 92) begin
				g = $urandom_range(4, 40);
			end
		end
		return g;
	endfunction

	// Driver: presents queued words and seed writes, honoring drain points.
	always @(posedge clk) begin : driver
		logic nv_word;
		logic nv_cfg;
		int   gap_left;
		int   settle_cnt;
		bit   sender_burst;
		draw_result_t res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left = 0;
			settle_cnt = 0;
			sender_burst = 1'b0;
		end else begin
			nv_word = s_axis_tvalid;
			nv_cfg = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				res = predict_word(slr_pkg::op_t'(s_axis_tuser), s_axis_tdata[30:0]);
				expected_words.push_back(res);
				op_cnt[s_axis_tuser]++;
				sent_cnt++;
				nv_word = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				seed_reg = cfg_data;
				seed_writes++;
				nv_cfg = 1'b0;
			end
			if (!nv_word && !nv_cfg) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() > 0) begin
					case (stim_q[0].kind)
						K_WORD: begin
							nv_word = 1'b1;
							s_axis_tdata <= {1'b0, stim_q[0].limit};
							s_axis_tuser <= stim_q[0].op;
							void'(stim_q.pop_front());
							if ($urandom_range(0, 49) == 0) begin
								sender_burst = !sender_burst;
							end
							gap_left = pick_gap(sender_burst);
						end
						K_SEED: begin
							nv_cfg = 1'b1;
							cfg_data <= stim_q[0].seed;
							void'(stim_q.pop_front());
						end
						default: begin
							if (result_cnt == sent_cnt) begin
								if (settle_cnt >= SETTLE_WAIT) begin
									settle_cnt = 0;
									void'(stim_q.pop_front());
								end else begin
									settle_cnt++;
								end
							end else begin
								settle_cnt = 0;
							end
						end
					endcase
				end
			end
			s_axis_tvalid <= nv_word;
			cfg_valid <= nv_cfg;
		end
	end

	// Monitor: random back-pressure plus one long hold, and the result check.
	always @(posedge clk) begin : monitor
		int  stall_left;
		bit  long_hold_done;
		bit  recv_burst;
		draw_result_t exp_w;
		slr_pkg::word_t got_raw;
		slr_pkg::word_t got_scaled;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			long_hold_done = 1'b0;
			recv_burst = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_cnt++;
				got_raw = m_axis_tdata[30:0];
				got_scaled = m_axis_tdata[61:31];
				if (expected_words.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected word raw %0d scaled %0d", $time,
						got_raw, got_scaled);
				end else begin
					exp_w = expected_words.pop_front();
					if (got_raw !== exp_w.raw) begin
						fail_cnt++;
						$display("%0t: raw_value expected %0d actual %0d", $time,
							exp_w.raw, got_raw);
					end
					if (got_scaled !== exp_w.scaled) begin
						fail_cnt++;
						$display("%0t: scaled_value expected %0d actual %0d", $time,
							exp_w.scaled, got_scaled);
					end
				end
			end
			if (!long_hold_done && result_cnt >= 80) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 49) == 0) begin
					recv_burst = !recv_burst;
				end
				stall_left = pick_gap(recv_burst);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int idle_cnt;
		if (!arst_n) begin
			idle_cnt = 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cnt = 0;
		end else begin
			idle_cnt++;
			if (idle_cnt >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, idle_cnt);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int   phase_len;
		bit   first_phase;
		sent_cnt = 0;
		result_cnt = 0;
		fail_cnt = 0;
		seed_writes = 0;
		op_cnt = '{default: 0};
		words_planned = 0;
		snapshot_planned = 1'b0;
		seed_reg = slr_pkg::RESET_SEED;
		refill_from_seed();

		// Directed: limit extremes, snapshot round trip, reseed and seed extremes.
		push_word(slr_pkg::OP_DRAW, '0);
		push_word(slr_pkg::OP_DRAW, '1);
		push_word(slr_pkg::OP_DRAW, 31'd1);
		push_word(slr_pkg::OP_DRAW, pick_limit());
		push_word(slr_pkg::OP_SAVE, pick_limit());
		snapshot_planned = 1'b1;
		push_word(slr_pkg::OP_DRAW, 31'h7FFF_FFFE);
		push_word(slr_pkg::OP_DRAW, 31'h4000_0000);
		push_word(slr_pkg::OP_DRAW, 31'h2AAA_AAAA);
		push_word(slr_pkg::OP_RESTORE, '1);
		push_word(slr_pkg::OP_DRAW, 31'h7FFF_FFFE);
		push_word(slr_pkg::OP_DRAW, 31'h4000_0000);
		push_word(slr_pkg::OP_DRAW, 31'h2AAA_AAAA);
		push_word(slr_pkg::OP_RESEED, '0);
		push_word(slr_pkg::OP_DRAW, '1);
		push_drain();
		push_seed('0);
		push_word(slr_pkg::OP_RESEED, pick_limit());
		push_word(slr_pkg::OP_DRAW, '1);
		push_word(slr_pkg::OP_DRAW, '1);
		push_drain();
		push_seed('1);
		push_word(slr_pkg::OP_RESEED, pick_limit());
		push_word(slr_pkg::OP_DRAW, '1);
		push_word(slr_pkg::OP_DRAW, '1);
		push_word(slr_pkg::OP_DRAW, 31'h5555_5555);

		first_phase = 1'b1;
		while (words_planned < WORD_TARGET) begin
			push_drain();
			push_seed(pick_seed());
			if ($urandom_range(0, 3) != 0) begin
				push_word(slr_pkg::OP_RESEED, pick_limit());
			end
			phase_len = first_phase ? 200 : $urandom_range(30, 150);
			first_phase = 1'b0;
			repeat (phase_len) begin
				push_word(pick_op(), pick_limit());
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || s_axis_tvalid || cfg_valid) begin
			@(negedge clk);
		end
		while (result_cnt != sent_cnt) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		if (expected_words.size() != 0) begin
			fail_cnt++;
			$display("%0t: %0d expected words never arrived", $time, expected_words.size());
		end
		$display("Run covered %0d words (%0d draws, %0d saves, %0d restores, %0d reseeds),",
			sent_cnt, op_cnt[slr_pkg::OP_DRAW], op_cnt[slr_pkg::OP_SAVE],
			op_cnt[slr_pkg::OP_RESTORE], op_cnt[slr_pkg::OP_RESEED]);
		$display("%0d seed writes and %0d results checked, %0d errors.",
			seed_writes, result_cnt, fail_cnt);
		if (fail_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
